// ===== design/eiuf_pkg.sv =====
// Shared types, codes and constants of the Ethernet / IPv4 / UDP header filter.
// No dependencies; every other design file refers to this package by scoped name.
`timescale 1ns / 1ps

package eiuf_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNCATED = 3'd1,
		ST_NOT_IPV4  = 3'd2,
		ST_BAD_VER   = 3'd3,
		ST_FRAGMENT  = 3'd4,
		ST_NOT_UDP   = 3'd5,
		ST_UDP_LEN   = 3'd6,
		ST_PORT      = 3'd7
	} status_t;

	// Register map (index taken from paddr[2])
	localparam logic REG_WANTED_DEST_PORT = 1'b0;
	localparam logic [15:0] DNS_PORT = 16'd53;

	localparam int unsigned ETH_HDR_BYTES    = 14;
	localparam int unsigned IP_HDR_MIN_BYTES = 20;
	localparam int unsigned UDP_HDR_BYTES    = 8;
	localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  PROTO_UDP        = 8'd17;
	localparam logic [3:0]  IP_VERSION_4     = 4'd4;
	localparam logic [12:0] FRAG_MASK        = 13'h1fff;

	// Header fields captured so far in the current frame
	typedef struct packed {
		logic [15:0] ether_kind;
		logic [3:0]  ip_version;
		logic [3:0]  ip_header_words;
		logic [12:0] fragment_offset;
		logic [7:0]  ip_protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] udp_length;
	} hdr_t;

	// One result beat
	typedef struct packed {
		status_t     status;
		logic        accepted;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} result_t;

	// Frame index of the first UDP header byte: 14 + 4 * IHL
	function automatic logic [6:0] udp_start(input logic [3:0] ihl);
		return 7'(ETH_HDR_BYTES) + {1'b0, ihl, 2'b00};
	endfunction

endpackage

// ===== design/eiuf_capture.sv =====
// Per-frame byte counter and header field capture registers.
// Depends on eiuf_pkg (hdr_t, udp_start).
`timescale 1ns / 1ps

module eiuf_capture #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             frame_byte,
	input  logic                   frame_last,
	output logic [LENGTH_BITS-1:0] byte_index,
	output eiuf_pkg::hdr_t         hdr_next
);

	localparam logic [LENGTH_BITS-1:0] IDX_MAX = '1;

	logic [LENGTH_BITS-1:0] byte_index_q;
	eiuf_pkg::hdr_t         hdr_q;

	logic [3:0]             ihl;
	logic [6:0]             start;
	logic [LENGTH_BITS-1:0] udp_rel;
	logic                   in_udp;

	assign byte_index = byte_index_q;

	always_comb begin
		// header length written by this very byte counts for the UDP window
		ihl     = (byte_index_q == LENGTH_BITS'(14)) ? frame_byte[3:0] : hdr_q.ip_header_words;
		start   = eiuf_pkg::udp_start(ihl);
		udp_rel = byte_index_q - LENGTH_BITS'(start);
		in_udp  = (byte_index_q >= LENGTH_BITS'(start)) && (udp_rel < LENGTH_BITS'(6));

		hdr_next = hdr_q;
		if (byte_index_q == LENGTH_BITS'(12)) hdr_next.ether_kind[15:8] = frame_byte;
		if (byte_index_q == LENGTH_BITS'(13)) hdr_next.ether_kind[7:0] = frame_byte;
		if (byte_index_q == LENGTH_BITS'(14)) begin
			hdr_next.ip_version      = frame_byte[7:4];
			hdr_next.ip_header_words = frame_byte[3:0];
		end
		if (byte_index_q == LENGTH_BITS'(20)) hdr_next.fragment_offset[12:8] = frame_byte[4:0];
		if (byte_index_q == LENGTH_BITS'(21)) hdr_next.fragment_offset[7:0] = frame_byte;
		if (byte_index_q == LENGTH_BITS'(23)) hdr_next.ip_protocol = frame_byte;
		if (byte_index_q >= LENGTH_BITS'(26) && byte_index_q <= LENGTH_BITS'(29))
			hdr_next.src_addr = {hdr_q.src_addr[23:0], frame_byte};
		if (byte_index_q >= LENGTH_BITS'(30) && byte_index_q <= LENGTH_BITS'(33))
			hdr_next.dst_addr = {hdr_q.dst_addr[23:0], frame_byte};
		if (in_udp) begin
			case (udp_rel[2:0])
				3'd0: hdr_next.src_port[15:8]   = frame_byte;
				3'd1: hdr_next.src_port[7:0]    = frame_byte;
				3'd2: hdr_next.dst_port[15:8]   = frame_byte;
				3'd3: hdr_next.dst_port[7:0]    = frame_byte;
				3'd4: hdr_next.udp_length[15:8] = frame_byte;
				3'd5: hdr_next.udp_length[7:0]  = frame_byte;
				default: ;
			endcase
		end
	end

	// clear on the last beat, otherwise advance with saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			hdr_q        <= '0;
		end else if (step) begin
			if (frame_last) begin
				byte_index_q <= '0;
				hdr_q        <= '0;
			end else begin
				hdr_q <= hdr_next;
				if (byte_index_q != IDX_MAX) byte_index_q <= byte_index_q + 1'b1;
			end
		end
	end

endmodule

// ===== design/eiuf_check.sv =====
// Frame acceptance checks and result formatting for the final byte.
// Depends on eiuf_pkg (hdr_t, result_t, status codes, udp_start).
`timescale 1ns / 1ps

module eiuf_check #(
	parameter int LENGTH_BITS = 16
) (
	input  logic [LENGTH_BITS-1:0] byte_index,
	input  eiuf_pkg::hdr_t         hdr,
	input  logic [15:0]            wanted_dest_port,
	output eiuf_pkg::result_t      result
);

	logic [LENGTH_BITS-1:0] len;
	logic [6:0]             start;
	logic [LENGTH_BITS-1:0] start_w;
	logic [LENGTH_BITS-1:0] avail;
	eiuf_pkg::status_t      st;

	always_comb begin
		len     = (byte_index == '1) ? byte_index : byte_index + 1'b1;
		start   = eiuf_pkg::udp_start(hdr.ip_header_words);
		start_w = LENGTH_BITS'(start);
		avail   = len - start_w;

		if (len < LENGTH_BITS'(eiuf_pkg::ETH_HDR_BYTES))
			st = eiuf_pkg::ST_TRUNCATED;
		else if (hdr.ether_kind != eiuf_pkg::ETHERTYPE_IPV4)
			st = eiuf_pkg::ST_NOT_IPV4;
		else if (len < LENGTH_BITS'(eiuf_pkg::ETH_HDR_BYTES + eiuf_pkg::IP_HDR_MIN_BYTES))
			st = eiuf_pkg::ST_TRUNCATED;
		else if (hdr.ip_version != eiuf_pkg::IP_VERSION_4)
			st = eiuf_pkg::ST_BAD_VER;
		else if ((hdr.fragment_offset & eiuf_pkg::FRAG_MASK) != '0)
			st = eiuf_pkg::ST_FRAGMENT;
		else if (hdr.ip_protocol != eiuf_pkg::PROTO_UDP)
			st = eiuf_pkg::ST_NOT_UDP;
		else if (len < start_w + LENGTH_BITS'(eiuf_pkg::UDP_HDR_BYTES))
			st = eiuf_pkg::ST_TRUNCATED;
		else if ({1'b0, hdr.udp_length} > 17'(avail))
			st = eiuf_pkg::ST_UDP_LEN;
		else if (hdr.dst_port != wanted_dest_port)
			st = eiuf_pkg::ST_PORT;
		else
			st = eiuf_pkg::ST_OK;

		result          = '0;
		result.status   = st;
		result.accepted = (st == eiuf_pkg::ST_OK);
		if (st == eiuf_pkg::ST_OK || st == eiuf_pkg::ST_PORT) begin
			result.source_addr = hdr.src_addr;
			result.dest_addr   = hdr.dst_addr;
			result.source_port = hdr.src_port;
			result.dest_port   = hdr.dst_port;
		end
		if (st == eiuf_pkg::ST_OK) begin
			result.payload_offset = 16'(start) + 16'(eiuf_pkg::UDP_HDR_BYTES);
			result.payload_length = 16'(avail - LENGTH_BITS'(eiuf_pkg::UDP_HDR_BYTES));
		end
	end

endmodule

// ===== design/eth_ipv4_udp_header_filter.sv =====
// Ethernet / IPv4 / UDP header filter: top level with input stage, result register, APB port.
// Result beat: the frame's last byte passes the input stage, then loads the result register.
// Throughput: one frame byte per cycle; the single input stage only holds while a
// last byte waits for a result register that is still stalled.
// Reset (arst_n low, asynchronous): no beats in flight, frame state cleared,
// wanted_dest_port back to 53. Depends on eiuf_pkg, eiuf_capture, eiuf_check.
`timescale 1ns / 1ps

module eth_ipv4_udp_header_filter #(
	parameter int LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	// frame byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  frame_byte,
	input  logic        frame_last,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        accepted,
	output logic [31:0] source_addr,
	output logic [31:0] dest_addr,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [15:0] payload_offset,
	output logic [15:0] payload_length,

	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// ------------------------------------------------------------------
	// Configuration register: UDP destination port a frame must carry.
	// ------------------------------------------------------------------
	logic [15:0] wanted_dest_port_q;
	logic        cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == eiuf_pkg::REG_WANTED_DEST_PORT);
	assign prdata    = (paddr[2] == eiuf_pkg::REG_WANTED_DEST_PORT) ?
		{16'h0000, wanted_dest_port_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_dest_port_q <= eiuf_pkg::DNS_PORT;
		end else if (cfg_write) begin
			wanted_dest_port_q <= pwdata[15:0];
		end
	end

	// ------------------------------------------------------------------
	// Input stage. A byte in the stage always advances unless it is the
	// last byte of a frame and the result register is full and stalled.
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       go_s1;
	logic       out_valid_q;
	logic       in_take;

	assign go_s1    = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !go_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= frame_byte;
			last_s1 <= frame_last;
		end
	end

	// ------------------------------------------------------------------
	// Header capture and checks on the staged byte.
	// ------------------------------------------------------------------
	logic [LENGTH_BITS-1:0] byte_index;
	eiuf_pkg::hdr_t         hdr_next;
	eiuf_pkg::result_t      result;

	eiuf_capture #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (go_s1),
		.frame_byte (byte_s1),
		.frame_last (last_s1),
		.byte_index (byte_index),
		.hdr_next   (hdr_next)
	);

	eiuf_check #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_check (
		.byte_index       (byte_index),
		.hdr              (hdr_next),
		.wanted_dest_port (wanted_dest_port_q),
		.result           (result)
	);

	// ------------------------------------------------------------------
	// Result register: load on the last byte, drop once the beat is taken.
	// ------------------------------------------------------------------
	logic              load_out;
	eiuf_pkg::result_t result_q;

	assign load_out = go_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = result_q.status;
	assign accepted       = result_q.accepted;
	assign source_addr    = result_q.source_addr;
	assign dest_addr      = result_q.dest_addr;
	assign source_port    = result_q.source_port;
	assign dest_port      = result_q.dest_port;
	assign payload_offset = result_q.payload_offset;
	assign payload_length = result_q.payload_length;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// the input side only holds for a last byte behind a stalled, full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// a consumed last byte restarts the byte count
	a_index_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && last_s1) |=> (byte_index == '0))
		else $error("byte index not cleared after frame end");

	// rejected frames other than a port mismatch carry no addresses or ports
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != eiuf_pkg::ST_OK && status != eiuf_pkg::ST_PORT) |->
		(source_addr == '0 && dest_addr == '0 && source_port == '0 && dest_port == '0))
		else $error("rejected frame reports header fields");

	// payload location and the accepted flag only on an ok status
	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != eiuf_pkg::ST_OK) |->
		(!accepted && payload_offset == '0 && payload_length == '0))
		else $error("payload reported for a rejected frame");

endmodule

// ===== tb/sv/tb_eth_ipv4_udp_header_filter.sv =====
// Self-checking bench for eth_ipv4_udp_header_filter: byte stream in, one verdict beat per frame.
// Holds its own header parser and a verdict scoreboard; depends on eiuf_pkg and the DUT only.
`timescale 1ns / 1ps

// Track frame bytes as they are accepted, predict the verdict, and compare result beats.
class verdict_board;
	logic [15:0] wanted_port = eiuf_pkg::DNS_PORT;
	int unsigned errors = 0;
	eiuf_pkg::result_t expected_verdicts[$];

	logic [15:0] byte_idx = '0;
	logic [15:0] ether_kind = '0;
	logic [3:0]  ip_ver = '0;
	logic [3:0]  ihl = '0;
	logic [12:0] frag = '0;
	logic [7:0]  proto = '0;
	logic [31:0] src_ip = '0;
	logic [31:0] dst_ip = '0;
	logic [15:0] src_port = '0;
	logic [15:0] dst_port = '0;
	logic [15:0] udp_len = '0;

	function void clear_frame();
		byte_idx = '0;
		ether_kind = '0;
		ip_ver = '0;
		ihl = '0;
		frag = '0;
		proto = '0;
		src_ip = '0;
		dst_ip = '0;
		src_port = '0;
		dst_port = '0;
		udp_len = '0;
	endfunction

	// Capture header fields at their byte positions; on the last byte queue the verdict.
	function void note_byte(input logic [7:0] b, input logic last);
		int unsigned udp_at;
		int unsigned frame_len;
		eiuf_pkg::status_t verdict;
		eiuf_pkg::result_t r;
		if (byte_idx == 12) ether_kind[15:8] = b;
		if (byte_idx == 13) ether_kind[7:0] = b;
		if (byte_idx == 14) {ip_ver, ihl} = b;
		if (byte_idx == 20) frag[12:8] = b[4:0];
		if (byte_idx == 21) frag[7:0] = b;
		if (byte_idx == 23) proto = b;
		if (byte_idx >= 26 && byte_idx <= 29) src_ip = {src_ip[23:0], b};
		if (byte_idx >= 30 && byte_idx <= 33) dst_ip = {dst_ip[23:0], b};
		// UDP header follows the IP header as sized by IHL, so it may overlap it
		udp_at = eiuf_pkg::ETH_HDR_BYTES + 4 * ihl;
		if (byte_idx >= udp_at && byte_idx < udp_at + 6) begin
			case (byte_idx - udp_at)
				0: src_port[15:8] = b;
				1: src_port[7:0] = b;
				2: dst_port[15:8] = b;
				3: dst_port[7:0] = b;
				4: udp_len[15:8] = b;
				default: udp_len[7:0] = b;
			endcase
		end
		if (!last) begin
			if (byte_idx != 16'hffff) byte_idx++;
			return;
		end
		frame_len = byte_idx + 1;
		if (frame_len > 16'hffff) frame_len = 16'hffff;
		if (frame_len < eiuf_pkg::ETH_HDR_BYTES)
			verdict = eiuf_pkg::ST_TRUNCATED;
		else if (ether_kind != eiuf_pkg::ETHERTYPE_IPV4)
			verdict = eiuf_pkg::ST_NOT_IPV4;
		else if (frame_len < eiuf_pkg::ETH_HDR_BYTES + eiuf_pkg::IP_HDR_MIN_BYTES)
			verdict = eiuf_pkg::ST_TRUNCATED;
		else if (ip_ver != eiuf_pkg::IP_VERSION_4)
			verdict = eiuf_pkg::ST_BAD_VER;
		else if ((frag & eiuf_pkg::FRAG_MASK) != '0)
			verdict = eiuf_pkg::ST_FRAGMENT;
		else if (proto != eiuf_pkg::PROTO_UDP)
			verdict = eiuf_pkg::ST_NOT_UDP;
		else if (frame_len < udp_at + eiuf_pkg::UDP_HDR_BYTES)
			verdict = eiuf_pkg::ST_TRUNCATED;
		else if (udp_len > frame_len - udp_at)
			verdict = eiuf_pkg::ST_UDP_LEN;
		else if (dst_port != wanted_port)
			verdict = eiuf_pkg::ST_PORT;
		else
			verdict = eiuf_pkg::ST_OK;
		r = '0;
		r.status = verdict;
		r.accepted = (verdict == eiuf_pkg::ST_OK);
		if (verdict == eiuf_pkg::ST_OK || verdict == eiuf_pkg::ST_PORT) begin
			r.source_addr = src_ip;
			r.dest_addr = dst_ip;
			r.source_port = src_port;
			r.dest_port = dst_port;
		end
		if (verdict == eiuf_pkg::ST_OK) begin
			r.payload_offset = 16'(udp_at + eiuf_pkg::UDP_HDR_BYTES);
			r.payload_length = 16'(frame_len - udp_at - eiuf_pkg::UDP_HDR_BYTES);
		end
		expected_verdicts.push_back(r);
		clear_frame();
	endfunction

	function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_verdict(input eiuf_pkg::result_t got);
		eiuf_pkg::result_t want;
		if (expected_verdicts.size() == 0) begin
			$error("result beat with no frame pending, status %0d", got.status);
			errors++;
			return;
		end
		want = expected_verdicts.pop_front();
		check_field("status", want.status, got.status);
		check_field("accepted", want.accepted, got.accepted);
		check_field("source_addr", want.source_addr, got.source_addr);
		check_field("dest_addr", want.dest_addr, got.dest_addr);
		check_field("source_port", want.source_port, got.source_port);
		check_field("dest_port", want.dest_port, got.dest_port);
		check_field("payload_offset", want.payload_offset, got.payload_offset);
		check_field("payload_length", want.payload_length, got.payload_length);
	endfunction
endclass

module tb_eth_ipv4_udp_header_filter;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  frame_byte = '0;
	logic        frame_last = 1'b0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic        accepted;
	logic [31:0] source_addr;
	logic [31:0] dest_addr;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [15:0] payload_offset;
	logic [15:0] payload_length;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Percent chance per cycle that the sender holds off / the receiver stalls
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;

	verdict_board board = new;
	eiuf_pkg::result_t result_beat;

	eth_ipv4_udp_header_filter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_byte(frame_byte),
		.frame_last(frame_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.accepted(accepted),
		.source_addr(source_addr),
		.dest_addr(dest_addr),
		.source_port(source_port),
		.dest_port(dest_port),
		.payload_offset(payload_offset),
		.payload_length(payload_length),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// Receiver side: decide the stall for the next edge at every rising edge
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Pack the result ports into one beat for the scoreboard
	assign result_beat = {status, accepted, source_addr, dest_addr, source_port, dest_port,
		payload_offset, payload_length};

	// Sample at the falling edge, where valid and stall are settled for the coming edge;
	// a beat seen here with no stall is taken at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_verdict(result_beat);
	end

	// Offer one byte, hold it while stalled, and log it once the DUT takes it
	task automatic push_byte(input logic [7:0] b, input logic last);
		logic held;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_byte <= b;
		frame_last <= last;
		do begin
			@(negedge clk);
			held = in_stall;
			@(posedge clk);
		end while (held);
		board.note_byte(b, last);
	endtask

	task automatic send_frame(input logic [7:0] q[$]);
		for (int i = 0; i < q.size(); i++) push_byte(q[i], i == q.size() - 1);
	endtask

	// One APB transfer to the port register: setup cycle, then access until pready
	task automatic port_access(input logic wr, input logic [15:0] wval,
		output logic [31:0] rval);
		logic rdy;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {eiuf_pkg::REG_WANTED_DEST_PORT, 2'b00};
		// upper data bits are junk; the register keeps only the low half
		pwdata <= {16'($urandom), wval};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			rval = prdata;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Optionally write the wanted port, then read it back and compare
	task automatic program_port(input logic do_write, input logic [15:0] value);
		logic [31:0] rd;
		if (do_write) begin
			port_access(1'b1, value, rd);
			board.wanted_port = value;
		end
		port_access(1'b0, 16'h0, rd);
		if (rd[15:0] !== board.wanted_port) begin
			$error("wanted_dest_port: expected %0h, got %0h", board.wanted_port, rd[15:0]);
			board.errors++;
		end
	endtask

	// Drop valid, wait for every pending verdict, then let the pipeline drain
	task automatic settle();
		in_valid <= 1'b0;
		for (int i = 0; i < 50000 && board.expected_verdicts.size() != 0; i++) @(posedge clk);
		if (board.expected_verdicts.size() != 0) begin
			$error("%0d verdicts never arrived", board.expected_verdicts.size());
			board.errors++;
		end
		repeat (8) @(posedge clk);
	endtask

	function automatic void fill_frame(ref logic [7:0] q[$], input int unsigned len,
		input logic [7:0] value);
		q.delete();
		repeat (len) q.push_back(value);
	endfunction

	// Build an Ethernet/IPv4/UDP frame over random content. udp_delta sets the UDP length
	// relative to the bytes left from the UDP start; cut, when nonzero, ends the frame early.
	// Bytes that carry version/IHL, fragment offset or protocol are never overwritten by
	// UDP fields, so with a short IHL the overlapping UDP fields read those same bytes.
	function automatic void build_frame(ref logic [7:0] q[$], input logic [15:0] etype,
		input logic [3:0] ver, input logic [3:0] hdr_words, input logic [12:0] frag_off,
		input logic [7:0] ip_proto, input logic [15:0] dport, input int unsigned payload,
		input int udp_delta, input int unsigned cut);
		int unsigned udp_at;
		int unsigned total;
		int ulen;
		logic [7:0] udp_bytes[4];
		udp_at = 14 + 4 * hdr_words;
		total = ((udp_at + 8 > 34) ? udp_at + 8 : 34) + payload;
		q.delete();
		repeat (total) q.push_back(8'($urandom));
		q[12] = etype[15:8];
		q[13] = etype[7:0];
		q[14] = {ver, hdr_words};
		q[20] = {q[20][7:5], frag_off[12:8]};
		q[21] = frag_off[7:0];
		q[23] = ip_proto;
		ulen = int'(total - udp_at) + udp_delta;
		if (ulen < 0) ulen = 0;
		if (ulen > 65535) ulen = 65535;
		udp_bytes = '{dport[15:8], dport[7:0], 8'(ulen >> 8), 8'(ulen)};
		for (int k = 0; k < 4; k++) begin
			if (!(udp_at + 2 + k inside {14, 20, 21, 23})) q[udp_at + 2 + k] = udp_bytes[k];
		end
		if (cut != 0) while (q.size() > cut) q.pop_back();
	endfunction

	initial begin
		logic [7:0] fr[$];
		int unsigned phase_bytes;
		int unsigned pick;
		logic [3:0] hdr_words;

		// Reset: hold, then release on a rising edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 6; phase++) begin
			// Idling pattern: sender sparse / receiver heavy, then swapped, then none
			case (phase / 2)
				0: begin send_gap_pct = 6; stall_pct = 50; end
				1: begin send_gap_pct = 50; stall_pct = 6; end
				default: begin send_gap_pct = 0; stall_pct = 0; end
			endcase
			// Port register: reset value, then both extremes, a random value, 53 again, a random value
			case (phase)
				0: program_port(1'b0, 16'h0);
				1: program_port(1'b1, 16'h0000);
				2: program_port(1'b1, 16'hffff);
				4: program_port(1'b1, eiuf_pkg::DNS_PORT);
				default: program_port(1'b1, 16'($urandom));
			endcase

			if (phase == 0) begin
				// Directed frames, wanted port still 53 from reset
				fill_frame(fr, 1, 8'h00);
				send_frame(fr);
				fill_frame(fr, 13, 8'hff);
				send_frame(fr);
				// ends right after the ether type
				build_frame(fr, 16'h0800, 4, 5, 0, 17, 53, 8, 0, 14);
				send_frame(fr);
				build_frame(fr, 16'h86dd, 4, 5, 0, 17, 53, 8, 0, 0);
				send_frame(fr);
				build_frame(fr, 16'h0800, 6, 5, 0, 17, 53, 8, 0, 0);
				send_frame(fr);
				build_frame(fr, 16'h0800, 4, 5, 13'h1fff, 17, 53, 8, 0, 0);
				send_frame(fr);
				build_frame(fr, 16'h0800, 4, 5, 0, 6, 53, 8, 0, 0);
				send_frame(fr);
				// ends inside the UDP header
				build_frame(fr, 16'h0800, 4, 5, 0, 17, 53, 8, 0, 39);
				send_frame(fr);
				// UDP length one past the frame end, then exactly filling it
				build_frame(fr, 16'h0800, 4, 5, 0, 17, 53, 8, 1, 0);
				send_frame(fr);
				build_frame(fr, 16'h0800, 4, 5, 0, 17, 53, 0, 0, 0);
				send_frame(fr);
				build_frame(fr, 16'h0800, 4, 5, 0, 17, 54, 8, -2, 0);
				send_frame(fr);
				// longest options
				build_frame(fr, 16'h0800, 4, 15, 0, 17, 53, 4, -1, 0);
				send_frame(fr);
				// header length below 5: UDP fields overlap the IP header
				for (int h = 0; h < 5; h++) begin
					build_frame(fr, 16'h0800, 4, 4'(h), 0, 17, 53, 6, -3, 0);
					send_frame(fr);
				end
				fill_frame(fr, 64, 8'hff);
				send_frame(fr);
				fill_frame(fr, 64, 8'h00);
				send_frame(fr);
			end

			// Random frames: mostly well-formed with random faults, the rest raw noise
			phase_bytes = 0;
			while (phase_bytes < 60) begin
				if ($urandom_range(99) < 20) begin
					fill_frame(fr, $urandom_range(1, 60), 8'h00);
					foreach (fr[i]) fr[i] = 8'($urandom);
					if (fr.size() > 13 && $urandom_range(1) == 1) begin
						fr[12] = 8'h08;
						fr[13] = 8'h00;
						if (fr.size() > 14) fr[14] = 8'h45;
					end
				end else begin
					pick = $urandom_range(99);
					hdr_words = (pick < 70) ? 4'd5 :
						(pick < 85) ? 4'($urandom_range(6, 15)) : 4'($urandom_range(0, 4));
					build_frame(fr,
						($urandom_range(99) < 5) ? 16'($urandom) : eiuf_pkg::ETHERTYPE_IPV4,
						($urandom_range(99) < 5) ? 4'($urandom) : eiuf_pkg::IP_VERSION_4,
						hdr_words,
						($urandom_range(99) < 6) ? 13'($urandom_range(1, 8191)) : 13'h0,
						($urandom_range(99) < 5) ? 8'($urandom) : eiuf_pkg::PROTO_UDP,
						($urandom_range(99) < 80) ? board.wanted_port : 16'($urandom),
						($urandom_range(99) < 3) ? $urandom_range(200, 600) : $urandom_range(0, 16),
						($urandom_range(99) < 10) ? int'($urandom_range(1, 40))
							: -int'($urandom_range(0, 60)),
						($urandom_range(99) < 10) ? $urandom_range(1, 80) : 0);
				end
				send_frame(fr);
				phase_bytes += fr.size();
			end
			settle();
		end

		if (board.errors == 0)
			$display("tb_eth_ipv4_udp_header_filter passed");
		else
			$display("tb_eth_ipv4_udp_header_filter failed");
		$finish;
	end

	// Watchdog: stop a hung run
	initial begin
		#50ms;
		$display("tb_eth_ipv4_udp_header_filter failed");
		$finish;
	end

endmodule
